### rtl/core/usqt_pkg.sv
// ----------------------------------------------------------------------------
// usqt_pkg - shared types and constants of the UV-sphere quad tessellator
// Payload structs, queue entry, state types, register indexes and the
// CORDIC constant set.
// ----------------------------------------------------------------------------
package usqt_pkg;

	typedef struct packed {
		logic [10:0] theta_step;
		logic [9:0]  phi_step;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		logic signed [15:0] face_x;
		logic signed [15:0] face_y;
		logic signed [15:0] face_z;
		logic               last_vertex;
	} vtx_t;

	// angles in units of pi/65536, texture coordinates in Q1.16
	typedef struct packed {
		logic [17:0] ang_th0;
		logic [17:0] ang_th1;
		logic [17:0] ang_ph0;
		logic [17:0] ang_ph1;
		logic [16:0] tex_u0;
		logic [16:0] tex_u1;
		logic [16:0] tex_v0;
		logic [16:0] tex_v1;
	} qent_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_START,
		F_WAIT,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_CLOAD,
		B_CITER,
		B_CSTORE,
		B_MUL,
		B_SUM,
		B_SQ,
		B_ISQRT,
		B_DSTART,
		B_DWAIT,
		B_POS,
		B_OUT
	} back_state_t;

	localparam logic [2:0] CFG_CENTER_X = 3'd0;
	localparam logic [2:0] CFG_CENTER_Y = 3'd1;
	localparam logic [2:0] CFG_CENTER_Z = 3'd2;
	localparam logic [2:0] CFG_RADIUS   = 3'd3;
	localparam logic [2:0] CFG_STEPS    = 3'd4;

	// front divisions, in issue order
	localparam logic [2:0] DIV_TH0 = 3'd0;
	localparam logic [2:0] DIV_TH1 = 3'd1;
	localparam logic [2:0] DIV_PH0 = 3'd2;
	localparam logic [2:0] DIV_PH1 = 3'd3;
	localparam logic [2:0] DIV_U0  = 3'd4;
	localparam logic [2:0] DIV_U1  = 3'd5;

	localparam logic [31:0] PI_Q30   = 32'd3373259426;
	localparam logic [33:0] GAIN_Q30 = 34'd652032875;
	localparam int          CORDIC_MAX_ITERS = 24;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'd843314857;
			5'd1:    r = 32'd497837829;
			5'd2:    r = 32'd263043837;
			5'd3:    r = 32'd133525159;
			5'd4:    r = 32'd67021687;
			5'd5:    r = 32'd33543516;
			5'd6:    r = 32'd16775851;
			5'd7:    r = 32'd8388437;
			5'd8:    r = 32'd4194283;
			5'd9:    r = 32'd2097149;
			5'd10:   r = 32'd1048576;
			5'd11:   r = 32'd524288;
			5'd12:   r = 32'd262144;
			5'd13:   r = 32'd131072;
			5'd14:   r = 32'd65536;
			5'd15:   r = 32'd32768;
			5'd16:   r = 32'd16384;
			5'd17:   r = 32'd8192;
			5'd18:   r = 32'd4096;
			5'd19:   r = 32'd2048;
			5'd20:   r = 32'd1024;
			5'd21:   r = 32'd512;
			5'd22:   r = 32'd256;
			5'd23:   r = 32'd128;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/usqt_div.sv
// ----------------------------------------------------------------------------
// usqt_div - radix-2 restoring divider
// One quotient bit a cycle; the quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module usqt_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 12,
	parameter int QUO_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [QUO_W-1:0] sh_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, sh_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> QUO_W);
			sh_q  <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

endmodule

### rtl/core/usqt_fifo.sv
// ----------------------------------------------------------------------------
// usqt_fifo - two-entry queue between front and back
// Holds classified quads so that each side stalls on its own.
// ----------------------------------------------------------------------------
module usqt_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  usqt_pkg::qent_t push_data,
	output logic           full,
	input  logic           pop,
	output usqt_pkg::qent_t pop_data,
	output logic           empty
);

	usqt_pkg::qent_t ent_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_data;
	end

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

### rtl/core/usqt_front.sv
// ----------------------------------------------------------------------------
// usqt_front - request intake and angle classification
// Clamps the quad indexes, works out the four angles and texture
// coordinates with one shared divider, and queues the result.
// ----------------------------------------------------------------------------
module usqt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [10:0]     res,
	input  logic            req_valid,
	output logic            req_ready,
	input  usqt_pkg::req_t  req,
	output logic            push,
	output usqt_pkg::qent_t push_data,
	input  logic            full
);

	usqt_pkg::front_state_t state_q, state_d;

	logic [10:0] t_q;
	logic [9:0]  p_q;
	logic [2:0]  di_q;
	usqt_pkg::qent_t ent_q;

	logic [11:0] lim_t, s;
	logic [10:0] lim_p, t_c;
	logic [9:0]  p_c;
	logic [27:0] num;
	logic [11:0] den;
	logic        div_start, div_done;
	logic [17:0] quo;

	assign lim_t = {res, 1'b0} - 12'd1;
	assign lim_p = res - 11'd1;
	assign t_c   = ({1'b0, req.theta_step} > lim_t) ? lim_t[10:0] : req.theta_step;
	assign p_c   = ({1'b0, req.phi_step} > lim_p) ? lim_p[9:0] : req.phi_step;

	always_comb begin
		if (di_q == usqt_pkg::DIV_PH0 || di_q == usqt_pkg::DIV_PH1)
			s = {2'b00, p_q} + {11'd0, di_q[0]};
		else
			s = {1'b0, t_q} + {11'd0, di_q[0]};
		num = {s, 16'd0} + (di_q[2] ? {17'd0, res} : {18'd0, res[10:1]});
		den = di_q[2] ? {res, 1'b0} : {1'b0, res};
	end

	usqt_div #(.NUM_W(28), .DEN_W(12), .QUO_W(18)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= usqt_pkg::F_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		push      = 1'b0;
		unique case (state_q)
			usqt_pkg::F_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) state_d = usqt_pkg::F_START;
			end
			usqt_pkg::F_START: begin
				div_start = 1'b1;
				state_d   = usqt_pkg::F_WAIT;
			end
			usqt_pkg::F_WAIT: begin
				if (div_done)
					state_d = (di_q == usqt_pkg::DIV_U1) ? usqt_pkg::F_PUSH
						: usqt_pkg::F_START;
			end
			usqt_pkg::F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = usqt_pkg::F_IDLE;
				end
			end
			default: state_d = usqt_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == usqt_pkg::F_IDLE && req_valid) begin
			t_q  <= t_c;
			p_q  <= p_c;
			di_q <= usqt_pkg::DIV_TH0;
		end else if (state_q == usqt_pkg::F_WAIT && div_done) begin
			di_q <= di_q + 3'd1;
			unique case (di_q)
				usqt_pkg::DIV_TH0: ent_q.ang_th0 <= quo;
				usqt_pkg::DIV_TH1: ent_q.ang_th1 <= quo;
				usqt_pkg::DIV_PH0: begin
					ent_q.ang_ph0 <= quo;
					ent_q.tex_v0  <= 17'd65536 - quo[16:0];
				end
				usqt_pkg::DIV_PH1: begin
					ent_q.ang_ph1 <= quo;
					ent_q.tex_v1  <= 17'd65536 - quo[16:0];
				end
				usqt_pkg::DIV_U0: ent_q.tex_u0 <= quo[16:0];
				usqt_pkg::DIV_U1: ent_q.tex_u1 <= quo[16:0];
				default: ;
			endcase
		end
	end

	assign push_data = ent_q;

endmodule

### rtl/core/usqt_back.sv
// ----------------------------------------------------------------------------
// usqt_back - vertex sequencer
// Runs CORDIC, normals, face normal and positions for one queued quad on
// shared units, then hands out the four vertices through a register.
// ----------------------------------------------------------------------------
module usqt_back #(
	parameter int CORDIC_ITERS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic [30:0]        radius,
	output logic               pop,
	input  usqt_pkg::qent_t    q_data,
	input  logic               q_empty,
	output logic               vtx_valid,
	input  logic               vtx_ready,
	output usqt_pkg::vtx_t     vtx
);

	localparam int NITER = (CORDIC_ITERS < usqt_pkg::CORDIC_MAX_ITERS)
		? CORDIC_ITERS : usqt_pkg::CORDIC_MAX_ITERS;
	localparam logic [4:0] LAST_IT = 5'(NITER - 1);

	usqt_pkg::back_state_t state_q, state_d;
	usqt_pkg::qent_t       cur_q;
	usqt_pkg::vtx_t        vtx_q;
	logic                  ov_q;

	logic [4:0]         cnt_q, it_q;
	logic [1:0]         ai_q, qd_q, j_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [31:0] cth_q [2];
	logic signed [31:0] sth_q [2];
	logic signed [31:0] cph_q [2];
	logic signed [31:0] sph_q [2];
	logic signed [31:0] nx_q [4];
	logic signed [31:0] ny_q [4];
	logic signed [31:0] posx_q [4];
	logic signed [31:0] posy_q [4];
	logic signed [31:0] posz_q [4];
	logic signed [19:0] s16_q [3];
	logic signed [15:0] face_q [3];
	logic signed [63:0] prod_q;
	logic [37:0]        sq_q, v_q, res_q, bit_q;

	logic               load, div_start, div_done;
	logic signed [31:0] mul_a, mul_b;
	logic [14:0]        fquo;

	// --- CORDIC helpers
	logic [17:0]        ang_sel;
	logic [47:0]        zp;
	logic signed [33:0] xs, ys, at, xc, yc;

	always_comb begin
		case (ai_q)
			2'd0:    ang_sel = cur_q.ang_th0;
			2'd1:    ang_sel = cur_q.ang_th1;
			2'd2:    ang_sel = cur_q.ang_ph0;
			default: ang_sel = cur_q.ang_ph1;
		endcase
		zp = 48'(ang_sel[14:0]) * 48'(usqt_pkg::PI_Q30) + 48'd32768;
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
		at = $signed({2'b00, usqt_pkg::atan_q30(it_q)});
		xc = (x_q > 34'sd1073741824) ? 34'sd1073741824
			: ((x_q < -34'sd1073741824) ? -34'sd1073741824 : x_q);
		yc = (y_q > 34'sd1073741824) ? 34'sd1073741824
			: ((y_q < -34'sd1073741824) ? -34'sd1073741824 : y_q);
	end

	// --- indexes for products and reads
	logic [1:0] k_i, k_w, kp, nk;
	logic       ts_i, ps_i, ps_n;
	logic [2:0] widx;
	logic [3:0] pidx;
	logic [1:0] sidx;

	assign k_i  = cnt_q[2:1];
	assign ts_i = k_i[1];
	assign ps_i = k_i[1] ^ k_i[0];
	assign widx = cnt_q[2:0] - 3'd1;
	assign k_w  = widx[2:1];
	assign kp   = cnt_q[3:2];
	assign pidx = cnt_q[3:0] - 4'd1;
	assign nk   = (state_q == usqt_pkg::B_OUT) ? cnt_q[1:0] : kp;
	assign ps_n = nk[1] ^ nk[0];
	assign sidx = (state_q == usqt_pkg::B_SQ) ? cnt_q[1:0] : j_q;

	logic signed [31:0] n_x, n_y, n_z, s16_sel;
	assign n_x     = nx_q[nk];
	assign n_y     = ny_q[nk];
	assign n_z     = cph_q[ps_n];
	assign s16_sel = 32'(s16_q[sidx]);

	logic signed [63:0] prod_r;
	logic signed [31:0] rnd30;
	logic signed [33:0] off, psum, cen_sel;
	logic signed [31:0] pos_sat;
	assign prod_r = prod_q + 64'sd536870912;
	assign rnd30  = 32'(prod_r >>> 30);
	assign off    = 34'(prod_r >>> 30);
	always_comb begin
		case (pidx[1:0])
			2'd0:    cen_sel = 34'(center_x);
			2'd1:    cen_sel = 34'(center_y);
			default: cen_sel = 34'(center_z);
		endcase
		psum = cen_sel + off;
		if (psum > 34'sd2147483647)       pos_sat = 32'sh7fffffff;
		else if (psum < -34'sd2147483648) pos_sat = 32'sh80000000;
		else                               pos_sat = 32'(psum);
	end

	// --- face sum
	logic signed [33:0] sumx, sumy, sumz;
	assign sumx = 34'(nx_q[0]) + 34'(nx_q[1]) + 34'(nx_q[2]) + 34'(nx_q[3]);
	assign sumy = 34'(ny_q[0]) + 34'(ny_q[1]) + 34'(ny_q[2]) + 34'(ny_q[3]);
	assign sumz = 34'((34'(cph_q[0]) + 34'(cph_q[1])) <<< 1);

	// --- integer root step
	logic [37:0] rb;
	assign rb = res_q + bit_q;

	// --- face division
	logic [18:0] mag;
	logic [32:0] dnum;
	logic [15:0] fq;
	assign mag  = s16_sel[31] ? 19'(-s16_sel) : 19'(s16_sel);
	assign dnum = {mag, 14'd0} + {15'd0, res_q[18:1]};
	assign fq   = ({1'b0, fquo} > 16'd16384) ? 16'd16384 : {1'b0, fquo};

	usqt_div #(.NUM_W(33), .DEN_W(19), .QUO_W(15)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dnum),
		.den    (res_q[18:0]),
		.done   (div_done),
		.quo    (fquo)
	);

	// --- normal quantisation for the output
	function automatic logic signed [15:0] q14(input logic signed [31:0] n);
		logic signed [33:0] r;
		r = (34'(n) + 34'sd32768) >>> 16;
		if (r > 34'sd16384)       return 16'sd16384;
		else if (r < -34'sd16384) return -16'sd16384;
		else                      return 16'(r);
	endfunction

	// --- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usqt_pkg::B_IDLE;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load)           ov_q <= 1'b1;
			else if (vtx_ready) ov_q <= 1'b0;
			if (state_d != state_q)            cnt_q <= '0;
			else if (state_q == usqt_pkg::B_OUT) cnt_q <= cnt_q + {4'd0, load};
			else                                cnt_q <= cnt_q + 5'd1;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		load      = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			usqt_pkg::B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = usqt_pkg::B_CLOAD;
				end
			end
			usqt_pkg::B_CLOAD: state_d = usqt_pkg::B_CITER;
			usqt_pkg::B_CITER: begin
				if (it_q == LAST_IT) state_d = usqt_pkg::B_CSTORE;
			end
			usqt_pkg::B_CSTORE: begin
				state_d = (ai_q == 2'd3) ? usqt_pkg::B_MUL : usqt_pkg::B_CLOAD;
			end
			usqt_pkg::B_MUL: begin
				mul_a = cnt_q[0] ? sth_q[ts_i] : cth_q[ts_i];
				mul_b = sph_q[ps_i];
				if (cnt_q == 5'd8) state_d = usqt_pkg::B_SUM;
			end
			usqt_pkg::B_SUM: state_d = usqt_pkg::B_SQ;
			usqt_pkg::B_SQ: begin
				mul_a = s16_sel;
				mul_b = s16_sel;
				if (cnt_q == 5'd3) state_d = usqt_pkg::B_ISQRT;
			end
			usqt_pkg::B_ISQRT: begin
				if (cnt_q == 5'd18) state_d = usqt_pkg::B_DSTART;
			end
			usqt_pkg::B_DSTART: begin
				if (res_q == '0) begin
					state_d = usqt_pkg::B_POS;
				end else begin
					div_start = 1'b1;
					state_d   = usqt_pkg::B_DWAIT;
				end
			end
			usqt_pkg::B_DWAIT: begin
				if (div_done)
					state_d = (j_q == 2'd2) ? usqt_pkg::B_POS : usqt_pkg::B_DSTART;
			end
			usqt_pkg::B_POS: begin
				mul_a = $signed({1'b0, radius});
				case (cnt_q[1:0])
					2'd0:    mul_b = n_x;
					2'd1:    mul_b = n_y;
					2'd2:    mul_b = n_z;
					default: mul_b = '0;
				endcase
				if (cnt_q == 5'd16) state_d = usqt_pkg::B_OUT;
			end
			usqt_pkg::B_OUT: begin
				if (!ov_q || vtx_ready) begin
					load = 1'b1;
					if (cnt_q[1:0] == 2'd3) state_d = usqt_pkg::B_IDLE;
				end
			end
			default: state_d = usqt_pkg::B_IDLE;
		endcase
	end

	// --- datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			usqt_pkg::B_IDLE: begin
				cur_q <= q_data;
				ai_q  <= 2'd0;
			end
			usqt_pkg::B_CLOAD: begin
				qd_q <= ang_sel[16:15];
				z_q  <= $signed({2'b00, zp[47:16]});
				x_q  <= $signed(usqt_pkg::GAIN_Q30);
				y_q  <= '0;
				it_q <= '0;
			end
			usqt_pkg::B_CITER: begin
				it_q <= it_q + 5'd1;
				if (!z_q[33]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
			end
			usqt_pkg::B_CSTORE: begin
				logic signed [31:0] c, sn;
				case (qd_q)
					2'd0:    begin c = 32'(xc);  sn = 32'(yc);  end
					2'd1:    begin c = -32'(yc); sn = 32'(xc);  end
					2'd2:    begin c = -32'(xc); sn = -32'(yc); end
					default: begin c = 32'(yc);  sn = -32'(xc); end
				endcase
				if (ai_q[1]) begin
					cph_q[ai_q[0]] <= c;
					sph_q[ai_q[0]] <= sn;
				end else begin
					cth_q[ai_q[0]] <= c;
					sth_q[ai_q[0]] <= sn;
				end
				ai_q <= ai_q + 2'd1;
			end
			usqt_pkg::B_MUL: begin
				if (cnt_q != 5'd0) begin
					if (widx[0]) ny_q[k_w] <= rnd30;
					else         nx_q[k_w] <= rnd30;
				end
			end
			usqt_pkg::B_SUM: begin
				s16_q[0] <= 20'((sumx + 34'sd8192) >>> 14);
				s16_q[1] <= 20'((sumy + 34'sd8192) >>> 14);
				s16_q[2] <= 20'((sumz + 34'sd8192) >>> 14);
			end
			usqt_pkg::B_SQ: begin
				if (cnt_q == 5'd0)      sq_q <= '0;
				else if (cnt_q == 5'd3) begin
					v_q   <= sq_q + prod_q[37:0];
					res_q <= '0;
					bit_q <= 38'd1 << 36;
				end else                sq_q <= sq_q + prod_q[37:0];
			end
			usqt_pkg::B_ISQRT: begin
				if (v_q >= rb) begin
					v_q   <= v_q - rb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				j_q   <= 2'd0;
			end
			usqt_pkg::B_DSTART: begin
				if (res_q == '0) begin
					face_q[0] <= '0;
					face_q[1] <= '0;
					face_q[2] <= '0;
				end
			end
			usqt_pkg::B_DWAIT: begin
				if (div_done) begin
					face_q[j_q] <= s16_sel[31] ? -$signed(fq) : $signed(fq);
					j_q         <= j_q + 2'd1;
				end
			end
			usqt_pkg::B_POS: begin
				if (cnt_q != 5'd0) begin
					case (pidx[1:0])
						2'd0:    posx_q[pidx[3:2]] <= pos_sat;
						2'd1:    posy_q[pidx[3:2]] <= pos_sat;
						2'd2:    posz_q[pidx[3:2]] <= pos_sat;
						default: ;
					endcase
				end
			end
			usqt_pkg::B_OUT: begin
				if (load) begin
					vtx_q.pos_x       <= posx_q[cnt_q[1:0]];
					vtx_q.pos_y       <= posy_q[cnt_q[1:0]];
					vtx_q.pos_z       <= posz_q[cnt_q[1:0]];
					vtx_q.norm_x      <= q14(n_x);
					vtx_q.norm_y      <= q14(n_y);
					vtx_q.norm_z      <= q14(n_z);
					vtx_q.tex_u       <= cnt_q[1] ? cur_q.tex_u1 : cur_q.tex_u0;
					vtx_q.tex_v       <= ps_n ? cur_q.tex_v1 : cur_q.tex_v0;
					vtx_q.face_x      <= face_q[0];
					vtx_q.face_y      <= face_q[1];
					vtx_q.face_z      <= face_q[2];
					vtx_q.last_vertex <= cnt_q[1:0] == 2'd3;
				end
			end
			default: ;
		endcase
	end

	assign vtx_valid = ov_q;
	assign vtx       = vtx_q;

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (vtx_q.face_x <= 16'sd16384 && vtx_q.face_x >= -16'sd16384 &&
			vtx_q.norm_z <= 16'sd16384 && vtx_q.norm_z >= -16'sd16384))
		else $error("normal component beyond unit range");

endmodule

### rtl/core/uv_sphere_quad_tessellator.sv
// ----------------------------------------------------------------------------
// uv_sphere_quad_tessellator - UV-sphere quad to four vertices
// Takes a quad index and emits the quad's four vertices with position,
// normal, texture coordinates and the shared face normal.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  req     | in        | req_valid/req_ready  | req (theta_step, phi_step)
//  vtx     | out       | vtx_valid/vtx_ready  | vtx (one vertex per transfer)
//
//  The back sets the rate: CORDIC for each of the four angles, then products, root,
//  three face divisions, positions, pop and four vertex transfers for each quad.
//  The front needs six divisions per quad and runs ahead through a two-entry
//  queue. Reset is asynchronous, active low; cfg_ready is always high. A stalled
//  vtx holds its register and the back waits with the next vertex.
//
module uv_sphere_quad_tessellator #(
	parameter int MAX_STEPS    = 1024,
	parameter int CORDIC_ITERS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic           req_valid,
	output logic           req_ready,
	input  usqt_pkg::req_t req,
	output logic           vtx_valid,
	input  logic           vtx_ready,
	output usqt_pkg::vtx_t vtx
);

	// configuration registers
	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic [30:0]        radius_q;
	logic [10:0]        steps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= 31'd65536;
			steps_q    <= 11'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				usqt_pkg::CFG_CENTER_X: center_x_q <= cfg_data;
				usqt_pkg::CFG_CENTER_Y: center_y_q <= cfg_data;
				usqt_pkg::CFG_CENTER_Z: center_z_q <= cfg_data;
				usqt_pkg::CFG_RADIUS:   radius_q   <= cfg_data[30:0];
				usqt_pkg::CFG_STEPS:    steps_q    <= cfg_data[10:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// effective resolution: clamp to one up to MAX_STEPS
	logic [10:0] res;
	always_comb begin
		if (steps_q == 11'd0)                 res = 11'd1;
		else if (32'(steps_q) > MAX_STEPS)    res = 11'(MAX_STEPS);
		else                                  res = steps_q;
	end

	// front to back queue
	usqt_pkg::qent_t push_data, pop_data;
	logic            push, full, pop, empty;

	usqt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	usqt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// back: CORDIC, normals, face normal, positions, vertex output register
	usqt_back #(.CORDIC_ITERS(CORDIC_ITERS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.center_z  (center_z_q),
		.radius    (radius_q),
		.pop       (pop),
		.q_data    (pop_data),
		.q_empty   (empty),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.vtx       (vtx)
	);

endmodule

### tb/uv_sphere_quad_tessellator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uv_sphere_quad_tessellator_tb - self-checking bench of the sphere tessellator
// Sends quad indices over the request channel and checks each vertex transfer
// against a bit-exact behavioural model of the CORDIC, the normals, the
// positions, the texture coordinates and the face normal. Directed rows cover
// the extremes, saturated indices and resolution clamping; random quads follow
// under several register settings with random idling on both sides.
// ----------------------------------------------------------------------------
module uv_sphere_quad_tessellator_tb;

	localparam int MAX_STEPS    = 1024;
	localparam int CORDIC_ITERS = 16;
	localparam int CYCLE_LIMIT  = 2000000;
	// back sequencer latency per quad, with margin
	localparam int QUAD_CYCLES  = 400;

	logic           clk;
	logic           arst_n;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [2:0]     cfg_index;
	logic [31:0]    cfg_data;
	logic           req_valid;
	logic           req_ready;
	usqt_pkg::req_t req;
	logic           vtx_valid;
	logic           vtx_ready;
	usqt_pkg::vtx_t vtx;

	uv_sphere_quad_tessellator #(
		.MAX_STEPS(MAX_STEPS),
		.CORDIC_ITERS(CORDIC_ITERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.vtx_valid(vtx_valid),
		.vtx_ready(vtx_ready),
		.vtx(vtx)
	);

	// shadow copy of the register file
	logic signed [31:0] sh_cx, sh_cy, sh_cz;
	logic [30:0]        sh_radius;
	logic [10:0]        sh_steps;

	usqt_pkg::vtx_t vertex_queue[$];
	int     mismatches;
	int     cycles;
	bit     hold_off_req;   // ask the receiver for a long stall
	bit     hold_off_busy;

	// clock: period 4 ns
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("uv_sphere_quad_tessellator_tb: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// model arithmetic
	// ------------------------------------------------------------------------
	function automatic longint rnd_sh(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp64(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint atan_entry(input int i);
		longint tbl[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128};
		return tbl[i];
	endfunction

	// angle in units of pi/65536 -> cos, sin in Q30
	task automatic cordic_sincos(input longint unsigned ang, output longint c,
			output longint s);
		longint unsigned a, r;
		int     q, n;
		longint x, y, z, xs, ys;
		a = ang & 64'h1FFFF;
		q = int'(a >> 15);
		r = a & 64'h7FFF;
		z = longint'((r * 64'd3373259426 + 64'd32768) >> 16);
		x = 652032875;
		y = 0;
		n = CORDIC_ITERS < 24 ? CORDIC_ITERS : 24;
		for (int i = 0; i < n; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_entry(i);
			end else begin
				x += ys; y -= xs; z += atan_entry(i);
			end
		end
		x = clamp64(x, -64'sd1073741824, 64'sd1073741824);
		y = clamp64(y, -64'sd1073741824, 64'sd1073741824);
		case (q & 3)
			0: begin c = x;  s = y;  end
			1: begin c = -y; s = x;  end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] face_comp(input longint c, input longint unsigned len);
		longint unsigned m;
		longint q;
		m = c < 0 ? -c : c;
		q = longint'((m * 64'd16384 + len / 2) / len);
		if (q > 16384) q = 16384;
		return c < 0 ? 16'(-q) : 16'(q);
	endfunction

	// work out the four vertices of one quad and queue them
	task automatic predict_quad(input usqt_pkg::req_t r);
		longint unsigned res, t, p, at, ap, sq, len, vt, vp;
		longint cth[2], sth[2], cph[2], sph[2];
		longint nrm[4][3], sum[3], cen[3], face[3], off, pos, nq;
		int     dt[4], dp[4];
		usqt_pkg::vtx_t v;
		res = sh_steps;
		if (res < 1) res = 1;
		if (res > MAX_STEPS) res = MAX_STEPS;
		t = r.theta_step;
		if (t > 2 * res - 1) t = 2 * res - 1;
		p = r.phi_step;
		if (p > res - 1) p = res - 1;
		for (int k = 0; k < 2; k++) begin
			at = ((t + k) * 65536 + res / 2) / res;
			ap = ((p + k) * 65536 + res / 2) / res;
			cordic_sincos(at, cth[k], sth[k]);
			cordic_sincos(ap, cph[k], sph[k]);
		end
		dt = '{0, 0, 1, 1};
		dp = '{0, 1, 1, 0};
		sum = '{0, 0, 0};
		for (int k = 0; k < 4; k++) begin
			nrm[k][0] = rnd_sh(cth[dt[k]] * sph[dp[k]], 30);
			nrm[k][1] = rnd_sh(sth[dt[k]] * sph[dp[k]], 30);
			nrm[k][2] = cph[dp[k]];
			for (int j = 0; j < 3; j++) sum[j] += nrm[k][j];
		end
		sq = 0;
		for (int j = 0; j < 3; j++) begin
			sum[j] = rnd_sh(sum[j], 14);
			sq += longint'(sum[j] * sum[j]);
		end
		len = floor_sqrt(sq);
		face = '{0, 0, 0};
		if (len != 0)
			for (int j = 0; j < 3; j++) face[j] = longint'($signed(face_comp(sum[j], len)));
		cen = '{sh_cx, sh_cy, sh_cz};
		for (int k = 0; k < 4; k++) begin
			vt = t + dt[k];
			vp = p + dp[k];
			for (int j = 0; j < 3; j++) begin
				off = rnd_sh(longint'(sh_radius) * nrm[k][j], 30);
				pos = clamp64(cen[j] + off, -64'sd2147483648, 64'sd2147483647);
				nq  = clamp64(rnd_sh(nrm[k][j], 16), -16384, 16384);
				case (j)
					0: begin v.pos_x = 32'(pos); v.norm_x = 16'(nq); v.face_x = 16'(face[j]); end
					1: begin v.pos_y = 32'(pos); v.norm_y = 16'(nq); v.face_y = 16'(face[j]); end
					default: begin
						v.pos_z = 32'(pos); v.norm_z = 16'(nq); v.face_z = 16'(face[j]);
					end
				endcase
			end
			v.tex_u = 17'((vt * 65536 + res) / (2 * res));
			v.tex_v = 17'(65536 - (vp * 65536 + res / 2) / res);
			v.last_vertex = (k == 3);
			vertex_queue.push_back(v);
		end
	endtask

	// ------------------------------------------------------------------------
	// vertex receiver: random stalls, long hold-off on request
	// ------------------------------------------------------------------------
	task automatic note_mismatch(input string what, input usqt_pkg::vtx_t exp_v,
			input usqt_pkg::vtx_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %h, got %h", what, exp_v, got);
	endtask

	initial begin : receiver
		int             wait_n;
		usqt_pkg::vtx_t exp_v;
		vtx_ready = 1'b0;
		hold_off_busy = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				// long stall, counted in cycles
				hold_off_busy = 1'b1;
				vtx_ready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_off_req = 1'b0;
				hold_off_busy = 1'b0;
			end
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (wait_n != 0) begin
				vtx_ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			vtx_ready <= 1'b1;
			do @(posedge clk); while (!vtx_valid);
			// transfer at this edge
			if (vertex_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected vertex %h", vtx);
			end else begin
				exp_v = vertex_queue.pop_front();
				if (vtx.pos_x !== exp_v.pos_x || vtx.pos_y !== exp_v.pos_y ||
						vtx.pos_z !== exp_v.pos_z)
					note_mismatch("position", exp_v, vtx);
				if (vtx.norm_x !== exp_v.norm_x || vtx.norm_y !== exp_v.norm_y ||
						vtx.norm_z !== exp_v.norm_z)
					note_mismatch("normal", exp_v, vtx);
				if (vtx.tex_u !== exp_v.tex_u || vtx.tex_v !== exp_v.tex_v)
					note_mismatch("texture", exp_v, vtx);
				if (vtx.face_x !== exp_v.face_x || vtx.face_y !== exp_v.face_y ||
						vtx.face_z !== exp_v.face_z)
					note_mismatch("face normal", exp_v, vtx);
				if (vtx.last_vertex !== exp_v.last_vertex)
					note_mismatch("last flag", exp_v, vtx);
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			usqt_pkg::CFG_CENTER_X: sh_cx = data;
			usqt_pkg::CFG_CENTER_Y: sh_cy = data;
			usqt_pkg::CFG_CENTER_Z: sh_cz = data;
			usqt_pkg::CFG_RADIUS:   sh_radius = data[30:0];
			usqt_pkg::CFG_STEPS:    sh_steps = data[10:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_quad(input usqt_pkg::req_t r, input bit idle_gaps);
		int wait_n;
		@(negedge clk);
		wait_n = idle_gaps ? $urandom_range(0, 6) : 0;
		if (wait_n != 0) begin
			req_valid <= 1'b0;
			repeat (wait_n) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		predict_quad(r);
		// leave valid high: the next call replaces the payload or drain() drops it
	endtask

	// drop the request, wait for every vertex, then let the block settle
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (vertex_queue.size() != 0 || hold_off_busy) @(negedge clk);
		repeat (QUAD_CYCLES) @(negedge clk);
	endtask

	task automatic set_sphere(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] cz, input logic [31:0] rad, input logic [31:0] steps);
		write_reg(usqt_pkg::CFG_CENTER_X, cx);
		write_reg(usqt_pkg::CFG_CENTER_Y, cy);
		write_reg(usqt_pkg::CFG_CENTER_Z, cz);
		write_reg(usqt_pkg::CFG_RADIUS, rad);
		write_reg(usqt_pkg::CFG_STEPS, steps);
	endtask

	task automatic random_phase(input int n);
		usqt_pkg::req_t r;
		int   res;
		res = sh_steps == 0 ? 1 : (sh_steps > MAX_STEPS ? MAX_STEPS : sh_steps);
		for (int i = 0; i < n; i++) begin
			// mostly in-range quads, some raw full-width noise for saturation
			if ($urandom_range(0, 9) < 8) begin
				r.theta_step = 11'($urandom_range(0, 2 * res - 1));
				r.phi_step   = 10'($urandom_range(0, res - 1));
			end else begin
				r.theta_step = 11'($urandom);
				r.phi_step   = 10'($urandom);
			end
			send_quad(r, i % 40 < 30);
		end
	endtask

	// directed rows: request and the register setting it runs under
	typedef struct {
		logic [10:0]    steps;
		logic [30:0]    radius;
		usqt_pkg::req_t r;
	} row_t;

	initial begin : sender
		row_t           rows[$];
		row_t           rw;
		usqt_pkg::vtx_t first_v;
		mismatches = 0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = usqt_pkg::CFG_CENTER_X;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		sh_cx = 0; sh_cy = 0; sh_cz = 0;
		sh_radius = 65536;
		sh_steps = 16;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset: quad (0,0) at R=16, unit sphere, north pole first
		send_quad('{theta_step: 11'd0, phi_step: 10'd0}, 1'b0);
		first_v = vertex_queue[0];
		if (first_v.tex_u !== 17'd0 || first_v.tex_v !== 17'd65536 ||
				first_v.pos_z !== 32'sd65536 || first_v.norm_z !== 16'sd16384) begin
			mismatches++;
			$display("reset quad prediction off: %h", first_v);
		end
		drain();

		// resolution zero, one, max, above max; indices at and beyond the range
		rows = '{
			'{11'd16,   31'd65536,      '{11'd31,    10'd15}},
			'{11'd16,   31'd65536,      '{11'd2047,  10'd1023}},
			'{11'd16,   31'd65536,      '{11'd32,    10'd16}},
			'{11'd0,    31'd65536,      '{11'd0,     10'd0}},
			'{11'd0,    31'd65536,      '{11'd2047,  10'd1023}},
			'{11'd1,    31'h7FFFFFFF,   '{11'd1,     10'd0}},
			'{11'd2,    31'd0,          '{11'd3,     10'd1}},
			'{11'd1024, 31'd65536,      '{11'd2047,  10'd1023}},
			'{11'd1024, 31'd65536,      '{11'd0,     10'd511}},
			'{11'd2047, 31'h7FFFFFFF,   '{11'd1365,  10'd682}},
			'{11'd4,    31'h7FFFFFFF,   '{11'd5,     10'd2}},
			'{11'd3,    31'd1,          '{11'd2,     10'd1}},
			'{11'd7,    31'h55555555,   '{11'd1234,  10'd345}},
			'{11'd512,  31'h2AAAAAAA,   '{11'd1023,  10'd256}}
		};
		foreach (rows[i]) begin
			rw = rows[i];
			if (rw.steps !== sh_steps || rw.radius !== sh_radius) begin
				drain();
				// saturating centres on the extreme radius rows
				if (rw.radius == 31'h7FFFFFFF)
					set_sphere(32'h7FFFFFFF, 32'h80000000, 32'h7FFF0000,
						{1'b0, rw.radius}, {21'h1FFFFF, rw.steps});
				else
					set_sphere(32'h00010000, 32'hFFFE0000, 32'h0, {1'b1, rw.radius},
						{21'h0, rw.steps});
			end
			send_quad(rw.r, 1'b1);
		end
		drain();

		// random phases over several settings
		set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 32'h00100000), 16);
		random_phase(120);
		// fill the block against a stalled receiver
		hold_off_req = 1'b1;
		random_phase(40);
		drain();
		// pause until every vertex has come
		set_sphere($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 64));
		random_phase(120);
		drain();
		set_sphere(32'h80000000, 32'h7FFFFFFF, $urandom, 32'h7FFFFFFF, 1024);
		random_phase(60);
		drain();
		set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 32'h01000000),
			$urandom_range(1, 8));
		random_phase(120);
		drain();

		if (mismatches == 0)
			$display("uv_sphere_quad_tessellator_tb: done, clean");
		else
			$display("uv_sphere_quad_tessellator_tb: done, errors");
		$finish;
	end

endmodule

### sim.f
rtl/core/usqt_pkg.sv
rtl/core/usqt_div.sv
rtl/core/usqt_fifo.sv
rtl/core/usqt_front.sv
rtl/core/usqt_back.sv
rtl/core/uv_sphere_quad_tessellator.sv
tb/uv_sphere_quad_tessellator_tb.sv
